@@ rtl/assert_macros.svh @@
// Assertion macros shared by the union-find forest RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released
`define KUF_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked at every edge; the property guards reset itself
`define KUF_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/kuf_pkg.sv @@
// Shared types and constants of the union-find forest block
package kuf_pkg;

  localparam int NODE_W   = 12;
  localparam int WEIGHT_W = 6;
  localparam int CNT_W    = 13;
  localparam int RANK_W   = 4;
  localparam int STATUS_W = 2;

  localparam logic [RANK_W-1:0]   RANK_MAX     = 4'd15;
  localparam logic [CNT_W-1:0]    CNT_RESET    = 13'd4096;
  localparam logic [WEIGHT_W-1:0] LAST_W_RESET = 6'd63;

  localparam int DEF_MAX_NODES  = 4096;
  localparam int DEF_MAX_WEIGHT = 64;

  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

  localparam logic KIND_CLEAR = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_RANGE,
    ST_ORDER,
    ST_ZERO
  } status_t;

  typedef enum logic [1:0] {
    OP_REPORT,
    OP_EDGE,
    OP_CLEAR
  } op_t;

  typedef enum logic [2:0] {
    BK_INIT,
    BK_IDLE,
    BK_FIND,
    BK_LINK,
    BK_BUMP,
    BK_SWEEP,
    BK_EMIT
  } back_state_t;

  typedef struct packed {
    op_t                 op;
    logic [NODE_W-1:0]   first_node;
    logic [NODE_W-1:0]   second_node;
    logic [WEIGHT_W-1:0] weight;
    status_t             status;
  } cmd_t;

endpackage

@@ rtl/kuf_in_if.sv @@
// Edge word channel: valid/ready with kind, two node indices and weight
interface kuf_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [kuf_pkg::NODE_W-1:0]    first_node;
  logic [kuf_pkg::NODE_W-1:0]    second_node;
  logic [kuf_pkg::WEIGHT_W-1:0]  weight;

  modport source (output valid, kind, first_node, second_node, weight, input ready);
  modport sink   (input valid, kind, first_node, second_node, weight, output ready);
endinterface

@@ rtl/kuf_out_if.sv @@
// Result word channel: valid/ready with taken flag, weight echo and status
interface kuf_out_if;
  logic                          valid;
  logic                          ready;
  logic                          edge_taken;
  logic [kuf_pkg::WEIGHT_W-1:0]  weight_out;
  logic [kuf_pkg::STATUS_W-1:0]  status;

  modport source (output valid, edge_taken, weight_out, status, input ready);
  modport sink   (input valid, edge_taken, weight_out, status, output ready);
endinterface

@@ rtl/kuf_front.sv @@
// Front end: accepts edge words, checks range, weight order and zero weight, hands commands to the queue
`include "assert_macros.svh"

module kuf_front #(
  parameter int MAX_NODES  = kuf_pkg::DEF_MAX_NODES,
  parameter int MAX_WEIGHT = kuf_pkg::DEF_MAX_WEIGHT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [kuf_pkg::CNT_W-1:0]  cfg_wdata,
  kuf_in_if.sink                     in_ch,
  input  logic                       init_done,
  output logic                       push_valid,
  input  logic                       push_ready,
  output kuf_pkg::cmd_t              push_cmd
);

  localparam int NC_W   = $clog2(MAX_NODES + 1);
  localparam int LIM_W  = (NC_W > kuf_pkg::CNT_W) ? NC_W : kuf_pkg::CNT_W;
  localparam int WMAX_W = $clog2(MAX_WEIGHT + 1);
  localparam int WCMP_W = (WMAX_W > kuf_pkg::WEIGHT_W) ? WMAX_W : kuf_pkg::WEIGHT_W;

  logic [kuf_pkg::CNT_W-1:0]    node_count_r;
  logic [kuf_pkg::WEIGHT_W-1:0] last_weight_r;
  logic [kuf_pkg::WEIGHT_W-1:0] last_weight_nxt;
  logic [LIM_W-1:0]             limit;
  logic                         nodes_ok;
  logic                         weight_big;
  logic                         accept;

  assign in_ch.ready = init_done && push_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push_valid  = accept;

  // Clamp the node count to the table depth
  assign limit = (LIM_W'(node_count_r) < LIM_W'(MAX_NODES)) ?
                 LIM_W'(node_count_r) : LIM_W'(MAX_NODES);

  assign nodes_ok   = (LIM_W'(in_ch.first_node) < limit) &&
                      (LIM_W'(in_ch.second_node) < limit);
  assign weight_big = WCMP_W'(in_ch.weight) >= WCMP_W'(MAX_WEIGHT);

  always_comb begin
    push_cmd.op          = kuf_pkg::OP_REPORT;
    push_cmd.first_node  = in_ch.first_node;
    push_cmd.second_node = in_ch.second_node;
    push_cmd.weight      = in_ch.weight;
    push_cmd.status      = kuf_pkg::ST_OK;
    last_weight_nxt      = last_weight_r;
    if (in_ch.kind == kuf_pkg::KIND_CLEAR) begin
      push_cmd.op     = kuf_pkg::OP_CLEAR;
      push_cmd.weight = '0;
      last_weight_nxt = kuf_pkg::LAST_W_RESET;
    end else if (!nodes_ok) begin
      push_cmd.status = kuf_pkg::ST_RANGE;
    end else if ((in_ch.weight > last_weight_r) || weight_big) begin
      push_cmd.status = kuf_pkg::ST_ORDER;
    end else if (in_ch.weight == '0) begin
      push_cmd.status = kuf_pkg::ST_ZERO;
      last_weight_nxt = '0;
    end else begin
      push_cmd.op     = kuf_pkg::OP_EDGE;
      last_weight_nxt = in_ch.weight;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r  <= kuf_pkg::CNT_RESET;
      last_weight_r <= kuf_pkg::LAST_W_RESET;
    end else begin
      if (cfg_we) begin
        node_count_r <= cfg_wdata;
      end
      if (accept) begin
        last_weight_r <= last_weight_nxt;
      end
    end
  end

  `KUF_ASSERT_ALWAYS(a_clear_restores_weight, clk, $past(rst_n) && $past(accept && (in_ch.kind == kuf_pkg::KIND_CLEAR)) |-> last_weight_r == kuf_pkg::LAST_W_RESET, "clear word did not restore last weight")
  `KUF_ASSERT(a_no_accept_in_init, clk, rst_n, accept |-> init_done && push_ready, "word accepted while back end cannot take it")

endmodule

@@ rtl/kuf_queue.sv @@
// Short command queue between the front end and the back end
`include "assert_macros.svh"

module kuf_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  kuf_pkg::cmd_t  push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output kuf_pkg::cmd_t  pop_cmd
);

  kuf_pkg::cmd_t                 q_r [kuf_pkg::QUEUE_DEPTH];
  logic [kuf_pkg::QUEUE_AW-1:0]  wr_ptr_r;
  logic [kuf_pkg::QUEUE_AW-1:0]  rd_ptr_r;
  logic [kuf_pkg::QUEUE_AW:0]    cnt_r;
  logic [kuf_pkg::QUEUE_AW:0]    cnt_nxt;
  logic                          do_push;
  logic                          do_pop;

  assign push_ready = cnt_r != (kuf_pkg::QUEUE_AW + 1)'(kuf_pkg::QUEUE_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_cmd    = q_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
  end

  `KUF_ASSERT(a_count_bound, clk, rst_n, cnt_r <= (kuf_pkg::QUEUE_AW + 1)'(kuf_pkg::QUEUE_DEPTH), "queue count above depth")
  `KUF_ASSERT(a_count_matches_ptrs, clk, rst_n, wr_ptr_r == rd_ptr_r + cnt_r[kuf_pkg::QUEUE_AW-1:0], "queue pointers disagree with count")

endmodule

@@ rtl/kuf_back.sv @@
// Back end: parent/rank memory, find walks with path splitting, union by rank
`include "assert_macros.svh"

module kuf_back #(
  parameter int MAX_NODES = kuf_pkg::DEF_MAX_NODES
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  kuf_pkg::cmd_t  cmd,
  output logic           init_done,
  kuf_out_if.source      out_ch
);

  localparam int NW    = $clog2(MAX_NODES);
  localparam int ENT_W = kuf_pkg::RANK_W + NW;

  kuf_pkg::back_state_t  state_r, state_nxt;
  kuf_pkg::cmd_t         cmd_r;

  logic [ENT_W-1:0]              mem [MAX_NODES];
  logic [ENT_W-1:0]              rdata_r;
  logic [NW-1:0]                 raddr;
  logic                          mem_we;
  logic [NW-1:0]                 waddr;
  logic [ENT_W-1:0]              wdata;

  logic [NW-1:0]                 cur_r, cur_nxt;
  logic [NW-1:0]                 prev_r, prev_nxt;
  logic [kuf_pkg::RANK_W-1:0]    prev_rank_r, prev_rank_nxt;
  logic                          prev_vld_r, prev_vld_nxt;
  logic                          side_r, side_nxt;
  logic [NW-1:0]                 ra_r, ra_nxt;
  logic [NW-1:0]                 rb_r, rb_nxt;
  logic [kuf_pkg::RANK_W-1:0]    rka_r, rka_nxt;
  logic [kuf_pkg::RANK_W-1:0]    rkb_r, rkb_nxt;
  logic [NW-1:0]                 idx_r, idx_nxt;
  logic                          taken_r, taken_nxt;

  logic                          out_valid_r;
  logic                          edge_taken_r;
  logic [kuf_pkg::WEIGHT_W-1:0]  weight_r;
  kuf_pkg::status_t              status_r;

  logic [NW-1:0]                 rd_par;
  logic [kuf_pkg::RANK_W-1:0]    rd_rank;
  logic                          is_root;
  logic                          idx_last;
  logic                          emit_go;
  logic [NW-1:0]                 a_idx, b_idx;

  assign rd_par    = rdata_r[NW-1:0];
  assign rd_rank   = rdata_r[ENT_W-1:NW];
  assign is_root   = rd_par == cur_r;
  assign idx_last  = idx_r == NW'(MAX_NODES - 1);
  assign emit_go   = !out_valid_r || out_ch.ready;
  assign a_idx     = NW'(cmd.first_node);
  assign b_idx     = NW'(cmd_r.second_node);
  assign cmd_ready = state_r == kuf_pkg::BK_IDLE;
  assign init_done = state_r != kuf_pkg::BK_INIT;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.edge_taken = edge_taken_r;
  assign out_ch.weight_out = weight_r;
  assign out_ch.status     = status_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      kuf_pkg::BK_INIT: begin
        if (idx_last) state_nxt = kuf_pkg::BK_IDLE;
      end
      kuf_pkg::BK_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            kuf_pkg::OP_EDGE:  state_nxt = kuf_pkg::BK_FIND;
            kuf_pkg::OP_CLEAR: state_nxt = kuf_pkg::BK_SWEEP;
            default:           state_nxt = kuf_pkg::BK_EMIT;
          endcase
        end
      end
      kuf_pkg::BK_FIND: begin
        if (is_root && side_r) state_nxt = kuf_pkg::BK_LINK;
      end
      kuf_pkg::BK_LINK: begin
        if ((ra_r != rb_r) && (rka_r == rkb_r)) begin
          state_nxt = kuf_pkg::BK_BUMP;
        end else begin
          state_nxt = kuf_pkg::BK_EMIT;
        end
      end
      kuf_pkg::BK_BUMP: state_nxt = kuf_pkg::BK_EMIT;
      kuf_pkg::BK_SWEEP: begin
        if (idx_last) state_nxt = kuf_pkg::BK_EMIT;
      end
      kuf_pkg::BK_EMIT: begin
        if (emit_go) state_nxt = kuf_pkg::BK_IDLE;
      end
      default: state_nxt = kuf_pkg::BK_INIT;
    endcase
  end

  always_comb begin
    raddr         = cur_r;
    mem_we        = 1'b0;
    waddr         = prev_r;
    wdata         = {prev_rank_r, rd_par};
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    prev_rank_nxt = prev_rank_r;
    prev_vld_nxt  = prev_vld_r;
    side_nxt      = side_r;
    ra_nxt        = ra_r;
    rb_nxt        = rb_r;
    rka_nxt       = rka_r;
    rkb_nxt       = rkb_r;
    idx_nxt       = idx_r;
    taken_nxt     = taken_r;
    case (state_r)
      kuf_pkg::BK_INIT, kuf_pkg::BK_SWEEP: begin
        mem_we  = 1'b1;
        waddr   = idx_r;
        wdata   = {{kuf_pkg::RANK_W{1'b0}}, idx_r};
        idx_nxt = idx_r + 1'b1;
      end
      kuf_pkg::BK_IDLE: begin
        // Start the walk from the first end as the command is taken
        raddr        = a_idx;
        cur_nxt      = a_idx;
        side_nxt     = 1'b0;
        prev_vld_nxt = 1'b0;
        taken_nxt    = 1'b0;
        idx_nxt      = '0;
      end
      kuf_pkg::BK_FIND: begin
        if (is_root) begin
          if (!side_r) begin
            ra_nxt       = cur_r;
            rka_nxt      = rd_rank;
            raddr        = b_idx;
            cur_nxt      = b_idx;
            side_nxt     = 1'b1;
            prev_vld_nxt = 1'b0;
          end else begin
            rb_nxt  = cur_r;
            rkb_nxt = rd_rank;
          end
        end else begin
          // Advance to the parent; point the previous node at it
          raddr         = rd_par;
          cur_nxt       = rd_par;
          mem_we        = prev_vld_r;
          prev_nxt      = cur_r;
          prev_rank_nxt = rd_rank;
          prev_vld_nxt  = 1'b1;
        end
      end
      kuf_pkg::BK_LINK: begin
        if (ra_r != rb_r) begin
          taken_nxt = 1'b1;
          mem_we    = 1'b1;
          if (rka_r < rkb_r) begin
            waddr = ra_r;
            wdata = {rka_r, rb_r};
          end else begin
            waddr = rb_r;
            wdata = {rkb_r, ra_r};
          end
        end
      end
      kuf_pkg::BK_BUMP: begin
        mem_we = 1'b1;
        waddr  = ra_r;
        wdata  = {(rka_r == kuf_pkg::RANK_MAX) ? rka_r : rka_r + 1'b1, ra_r};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kuf_pkg::BK_INIT;
      idx_r       <= '0;
      prev_vld_r  <= 1'b0;
      side_r      <= 1'b0;
      taken_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      idx_r      <= idx_nxt;
      prev_vld_r <= prev_vld_nxt;
      side_r     <= side_nxt;
      taken_r    <= taken_nxt;
      if ((state_r == kuf_pkg::BK_EMIT) && emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    prev_r      <= prev_nxt;
    prev_rank_r <= prev_rank_nxt;
    ra_r        <= ra_nxt;
    rb_r        <= rb_nxt;
    rka_r       <= rka_nxt;
    rkb_r       <= rkb_nxt;
    if (cmd_valid && cmd_ready) begin
      cmd_r <= cmd;
    end
    if ((state_r == kuf_pkg::BK_EMIT) && emit_go) begin
      edge_taken_r <= taken_r;
      weight_r     <= cmd_r.weight;
      status_r     <= cmd_r.status;
    end
  end

  `KUF_ASSERT(a_taken_is_ok, clk, rst_n, out_valid_r && edge_taken_r |-> status_r == kuf_pkg::ST_OK, "edge taken with bad status")
  `KUF_ASSERT(a_no_result_in_init, clk, rst_n, state_r == kuf_pkg::BK_INIT |-> !out_valid_r, "result shown during init sweep")
  `KUF_ASSERT(a_link_after_find, clk, rst_n, state_r == kuf_pkg::BK_LINK |-> $past(state_r) == kuf_pkg::BK_FIND && side_r, "link without both roots")

endmodule

@@ rtl/kruskal_union_find_forest.sv @@
// Edge word: the back end walks from each end to its root (da and db hops, splitting the path),
// then links the roots in LINK; a rank bump on a tied union adds the BUMP state before EMIT.
// The back end runs one word at a time and takes no new word until its result is registered;
// words wait in a queue of four. Words that fail a check or carry zero weight go straight to EMIT.
// A clear word sweeps all MAX_NODES table entries before its result shows.
// Reset (rst_n low, synchronous) starts a sweep of all MAX_NODES table entries; in_ch.ready stays low.
module kruskal_union_find_forest #(
  parameter int MAX_NODES  = kuf_pkg::DEF_MAX_NODES,
  parameter int MAX_WEIGHT = kuf_pkg::DEF_MAX_WEIGHT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [kuf_pkg::CNT_W-1:0]  cfg_wdata,
  kuf_in_if.sink                     in_ch,
  kuf_out_if.source                  out_ch
);

  logic           init_done;
  logic           push_valid;
  logic           push_ready;
  kuf_pkg::cmd_t  push_cmd;
  logic           pop_valid;
  logic           pop_ready;
  kuf_pkg::cmd_t  pop_cmd;

  kuf_front #(
    .MAX_NODES  (MAX_NODES),
    .MAX_WEIGHT (MAX_WEIGHT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_ch      (in_ch),
    .init_done  (init_done),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  kuf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  kuf_back #(
    .MAX_NODES (MAX_NODES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (pop_valid),
    .cmd_ready (pop_ready),
    .cmd       (pop_cmd),
    .init_done (init_done),
    .out_ch    (out_ch)
  );

endmodule
